// ===== rtl/core/ssh_dfr_pkg.sv =====
// Shared types and constants for the SSH packet deframer.
// Depends on nothing; the interfaces and every module in rtl/core use it.
package ssh_dfr_pkg;

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned POS_W  = 33;   // byte index, saturating
    localparam int unsigned LEN_W  = 32;   // packet length field
    localparam int unsigned END_W  = 34;   // payload end index, L - P + 4

    // Packet layout
    localparam logic [POS_W-1:0] LEN_LAST_IDX = POS_W'(3);  // last length byte
    localparam logic [POS_W-1:0] PAD_IDX      = POS_W'(4);  // padding-length byte
    localparam logic [END_W-1:0] HDR_BYTES    = END_W'(4);  // header bytes minus one
    localparam logic [POS_W-1:0] POS_MAX      = '1;

    // Completion status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_RUNT      = 2'd1;  // under six bytes
    localparam logic [STAT_W-1:0] ST_TRUNCATED = 2'd2;  // payload incomplete

    // One result transaction
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              out_done;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage

// ===== rtl/core/ssh_dfr_if.sv =====
// Valid/ready channel interfaces for the SSH packet deframer.
// Depends on ssh_dfr_pkg for field widths.
interface ssh_dfr_in_if;
    logic                            valid;
    logic                            ready;
    logic [ssh_dfr_pkg::BYTE_W-1:0]  in_byte;
    logic                            in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ssh_dfr_out_if;
    logic                            valid;
    logic                            ready;
    logic [ssh_dfr_pkg::BYTE_W-1:0]  out_byte;
    logic                            out_valid;
    logic                            out_done;
    logic [ssh_dfr_pkg::STAT_W-1:0]  status;

    modport source (output valid, output out_byte, output out_valid, output out_done,
                    output status, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_done,
                    input status, output ready);
endinterface

// ===== rtl/core/ssh_packet_deframer_top.sv =====
// SSH binary packet deframer: strips length, padding-length and padding bytes.
// Depends on ssh_dfr_pkg and the channel interfaces in ssh_dfr_if.sv.
//
//  Channel  Dir  Fields                                   Transaction when
//  i_in     in   in_byte, in_last                         valid && ready
//  o_out    out  out_byte, out_valid, out_done, status    valid && ready
//
//  One byte per cycle while the skid slot is empty; each result leaves from a register.
//  Per-byte work is one counter step and 34-bit compares against the
//  payload end index, which is registered when the padding-length byte arrives.
//  Reset (synchronous, active low) clears the packet state except the end index and empties both output slots.
//  A skid slot behind the output register absorbs one result while the sink
//  stalls; input ready drops only while that slot is full.
module ssh_packet_deframer_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ssh_dfr_in_if.sink            i_in,
    ssh_dfr_out_if.source         o_out
);

    // Packet state
    logic [ssh_dfr_pkg::POS_W-1:0] r_pos, n_pos;
    logic [ssh_dfr_pkg::LEN_W-1:0] r_len, n_len;
    logic                          r_pad_ok, n_pad_ok;
    logic [ssh_dfr_pkg::END_W-1:0] r_end, n_end;

    // Output register and skid slot
    ssh_dfr_pkg::t_result r_out, r_skid, w_res;
    logic                 r_out_vld, r_skid_vld;

    logic w_accept;
    logic w_produce;
    logic w_is_payload;
    logic w_out_fire;
    logic w_out_free;
    logic [ssh_dfr_pkg::END_W-1:0] w_count;

    assign i_in.ready = !r_skid_vld;
    assign w_accept   = i_in.valid && !r_skid_vld;
    assign w_out_fire = r_out_vld && o_out.ready;
    assign w_out_free = !r_out_vld || w_out_fire;

    // Byte classification and completion status
    always_comb begin
        w_count      = {1'b0, r_pos} + ssh_dfr_pkg::END_W'(1);
        w_is_payload = (r_pos > ssh_dfr_pkg::PAD_IDX) && r_pad_ok &&
                       ({1'b0, r_pos} < r_end);

        w_res.out_byte  = w_is_payload ? i_in.in_byte : '0;
        w_res.out_valid = w_is_payload;
        w_res.out_done  = i_in.in_last;
        w_res.status    = ssh_dfr_pkg::ST_OK;
        if (i_in.in_last) begin
            if (r_pos <= ssh_dfr_pkg::PAD_IDX) begin
                w_res.status = ssh_dfr_pkg::ST_RUNT;
            end else if (!r_pad_ok || (w_count < r_end)) begin
                w_res.status = ssh_dfr_pkg::ST_TRUNCATED;
            end
        end
        w_produce = w_accept && (i_in.in_last || w_is_payload);
    end

    // Header capture and position counter
    always_comb begin
        n_pos    = r_pos;
        n_len    = r_len;
        n_pad_ok = r_pad_ok;
        n_end    = r_end;
        if (w_accept) begin
            if (r_pos <= ssh_dfr_pkg::LEN_LAST_IDX) begin
                n_len = {r_len[ssh_dfr_pkg::LEN_W-ssh_dfr_pkg::BYTE_W-1:0], i_in.in_byte};
            end
            if (r_pos == ssh_dfr_pkg::PAD_IDX) begin
                // payload ends before index L - P + 4 when P + 1 <= L
                n_pad_ok = r_len > ssh_dfr_pkg::LEN_W'(i_in.in_byte);
                n_end    = {2'b00, r_len} - ssh_dfr_pkg::END_W'(i_in.in_byte)
                           + ssh_dfr_pkg::HDR_BYTES;
            end
            if (r_pos != ssh_dfr_pkg::POS_MAX) begin
                n_pos = r_pos + ssh_dfr_pkg::POS_W'(1);
            end
            if (i_in.in_last) begin
                n_pos    = '0;
                n_len    = '0;
                n_pad_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_len    <= '0;
            r_pad_ok <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_pad_ok <= n_pad_ok;
        end
        r_end <= n_end;
    end

    // Output register with skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_out_free) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= w_produce;
                end
            end else if (w_produce) begin
                r_skid_vld <= 1'b1;
            end
        end
        if (w_out_free) begin
            r_out <= r_skid_vld ? r_skid : w_res;
        end
        if (!w_out_free && w_produce) begin
            r_skid <= w_res;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.out_byte  = r_out.out_byte;
    assign o_out.out_valid = r_out.out_valid;
    assign o_out.out_done  = r_out.out_done;
    assign o_out.status    = r_out.status;

endmodule

// ===== rtl/core/ssh_dfr_chk.sv =====
// Port-level checker for the SSH packet deframer, bound to the top level.
// Depends on ssh_dfr_pkg and ssh_packet_deframer_top.
module ssh_dfr_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_ready,
    input  logic [ssh_dfr_pkg::BYTE_W-1:0]  i_out_byte,
    input  logic                            i_out_valid,
    input  logic                            i_out_done,
    input  logic [ssh_dfr_pkg::STAT_W-1:0]  i_status
);

    // Error status only on the closing transaction of a packet
    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status != ssh_dfr_pkg::ST_OK) |-> i_out_done)
        else $error("error status without done");

    // Status code stays within the defined set
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_status == ssh_dfr_pkg::ST_OK) ||
                    (i_status == ssh_dfr_pkg::ST_RUNT) ||
                    (i_status == ssh_dfr_pkg::ST_TRUNCATED))
        else $error("undefined status code");

    // A runt packet never reaches the payload, and non-payload bytes read zero
    a_runt_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ssh_dfr_pkg::ST_RUNT) |-> !i_out_valid)
        else $error("payload byte on runt packet");

    a_zero_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_out_valid |-> (i_out_byte == '0))
        else $error("nonzero byte without out_valid");

    // A stalled transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_out_byte) && $stable(i_out_valid)
                                && $stable(i_out_done) && $stable(i_status))
        else $error("stalled output changed");

endmodule

bind ssh_packet_deframer_top ssh_dfr_chk u_ssh_dfr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_out.valid),
    .i_ready     (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_valid (o_out.out_valid),
    .i_out_done  (o_out.out_done),
    .i_status    (o_out.status)
);
